/* rtl/stretch_blit_address_generator_macros.svh */
// ----------------------------------------------------------------------------
// Stretch blit address generator - assertion macros
// Concurrent checks sampled on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef STRETCH_BLIT_ADDRESS_GENERATOR_MACROS_SVH
`define STRETCH_BLIT_ADDRESS_GENERATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SBAG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stretch blit check failed");
`define SBAG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stretch blit pipeline check failed");
`else
`define SBAG_ASSERT_NOW(label, ante, cons)
`define SBAG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/sbag_pkg.sv */
// ----------------------------------------------------------------------------
// sbag_pkg
// Widths, register indexes, stage types and helper functions of the
// stretch blit address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sbag_pkg;

  localparam int COORD_W    = 16;
  localparam int STEP_W     = COORD_W - 1;
  localparam int OUT_W      = COORD_W + 1;
  localparam int MAG_W      = COORD_W;
  localparam int PROD_W     = STEP_W + MAG_W;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = (PROD_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_W      = DIV_STAGES * DIV_STEP;
  localparam int REM_W      = MAG_W + 1;

  localparam int SURF_W    = 15;
  localparam int PIXBITS_W = 6;
  localparam int BYTES_W   = 3;
  localparam int OFF_W     = 30;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 3;

  localparam int ROW_ALIGN_BITS = 32;
  localparam int ROW_ALIGN_BYTES = 4;
  localparam int BITS_PER_BYTE  = 8;
  localparam int ROW_SHIFT      = $clog2(ROW_ALIGN_BITS);
  localparam int ALIGN_SHIFT    = $clog2(ROW_ALIGN_BYTES);
  localparam int BYTE_SHIFT     = $clog2(BITS_PER_BYTE);

  localparam int STRIDE_SUM_W = SURF_W + PIXBITS_W + 1;
  localparam int STRIDE_W     = STRIDE_SUM_W - ROW_SHIFT + ALIGN_SHIFT;
  localparam int IDX_W        = (OUT_W - 1 < SURF_W) ? OUT_W - 1 : SURF_W;
  localparam int ROWMUL_W     = IDX_W + STRIDE_W;
  localparam int COLMUL_W     = IDX_W + BYTES_W;
  localparam int CMP_W        = (OUT_W > SURF_W) ? OUT_W : SURF_W;

  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DST_BITS   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_BITS   = CFG_IDX_W'(5);

  localparam logic [PIXBITS_W-1:0] PIXBITS_RESET = PIXBITS_W'(32);

  typedef struct packed {
    logic [STEP_W-1:0]  step_col;
    logic [STEP_W-1:0]  step_row;
    logic [COORD_W-1:0] dox;
    logic [COORD_W-1:0] doy;
    logic [COORD_W-1:0] dw;
    logic [COORD_W-1:0] dh;
    logic [COORD_W-1:0] sox;
    logic [COORD_W-1:0] soy;
    logic [COORD_W-1:0] sw;
    logic [COORD_W-1:0] sh;
  } req_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] word;
    logic [MAG_W-1:0] divisor;
  } div_t;

  typedef struct packed {
    logic               ok;
    logic [OUT_W-1:0]   dcol;
    logic [OUT_W-1:0]   drow;
    logic [COORD_W-1:0] sox;
    logic [COORD_W-1:0] soy;
    logic [MAG_W-1:0]   sabs_w;
    logic [MAG_W-1:0]   sabs_h;
    logic               mir_x;
    logic               mir_y;
  } side_t;

  typedef struct packed {
    logic             ok;
    logic [OUT_W-1:0] dcol;
    logic [OUT_W-1:0] drow;
    logic [OUT_W-1:0] scol;
    logic [OUT_W-1:0] srow;
  } coord_t;

  typedef struct packed {
    logic [OFF_W-1:0] drow_ofs;
    logic [OFF_W-1:0] dcol_ofs;
    logic [OFF_W-1:0] srow_ofs;
    logic [OFF_W-1:0] scol_ofs;
  } ofs_t;

  function automatic logic [MAG_W-1:0] magnitude(input logic [COORD_W-1:0] v);
    return v[COORD_W-1] ? MAG_W'(~v + COORD_W'(1)) : MAG_W'(v);
  endfunction

  function automatic logic [OUT_W-1:0] sext_out(input logic [COORD_W-1:0] v);
    return {{(OUT_W - COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic [OUT_W-1:0] dest_coord(input logic [COORD_W-1:0] org,
                                                  input logic [COORD_W-1:0] ext,
                                                  input logic [STEP_W-1:0]  step);
    logic [OUT_W-1:0] ofs;
    if (ext[COORD_W-1]) begin
      ofs = OUT_W'(magnitude(ext)) - OUT_W'(1) - OUT_W'(step);
    end else begin
      ofs = OUT_W'(step);
    end
    return sext_out(org) + ofs;
  endfunction

  function automatic logic [OUT_W-1:0] src_coord(input logic [COORD_W-1:0] org,
                                                 input logic [MAG_W-1:0]   sabs,
                                                 input logic               mirror,
                                                 input logic [OUT_W-1:0]   q);
    if (mirror) begin
      return sext_out(org) + OUT_W'(sabs) - OUT_W'(1) - q;
    end
    return sext_out(org) + q;
  endfunction

  function automatic logic in_surface(input logic [OUT_W-1:0]  coord,
                                      input logic [SURF_W-1:0] size);
    return !coord[OUT_W-1] && (CMP_W'(coord[OUT_W-2:0]) < CMP_W'(size));
  endfunction

  function automatic logic [STRIDE_W-1:0] row_stride(input logic [SURF_W-1:0]    width,
                                                     input logic [PIXBITS_W-1:0] bits);
    logic [STRIDE_SUM_W-1:0] sum;
    sum = STRIDE_SUM_W'(width) * STRIDE_SUM_W'(bits) + STRIDE_SUM_W'(ROW_ALIGN_BITS - 1);
    return STRIDE_W'(sum >> ROW_SHIFT) << ALIGN_SHIFT;
  endfunction

  function automatic logic [BYTES_W-1:0] byte_count(input logic [PIXBITS_W-1:0] bits);
    return BYTES_W'(bits >> BYTE_SHIFT);
  endfunction

  function automatic div_t div_stage(input div_t a);
    div_t             r;
    logic [REM_W-1:0] t;
    r = a;
    for (int i = 0; i < DIV_STEP; i++) begin
      t      = {r.rem[REM_W-2:0], r.word[DIV_W-1]};
      r.word = {r.word[DIV_W-2:0], 1'b0};
      if (t >= REM_W'(r.divisor)) begin
        r.rem     = t - REM_W'(r.divisor);
        r.word[0] = 1'b1;
      end else begin
        r.rem = t;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/stretch_blit_address_generator.sv */
// ----------------------------------------------------------------------------
// stretch_blit_address_generator
// Nearest-neighbor stretch blit addressing: mirrored destination and source
// coordinates, clipping, size checks and 4-byte aligned row byte offsets.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  cfg      in         cfg_we                cfg_index, cfg_data
//  in       in         in_valid / in_stall   step_col .. src_extent_h
//  out      out        out_valid / out_stall pixel_write .. pixel_bytes
//
//  One request per cycle while the output is not stalled; a result passes the
//  input register, the front register, the 8-stage pipelined restoring divider
//  (4 quotient bits per stage) and the clip, multiply and output registers.
//  The whole pipeline holds while the output register is full and stalled.
//  rst clears valid bits and sizes, sets pixel bits to 32; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stretch_blit_address_generator_macros.svh"

module stretch_blit_address_generator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [sbag_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sbag_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [sbag_pkg::STEP_W-1:0]           step_col,
  input  logic [sbag_pkg::STEP_W-1:0]           step_row,
  input  logic signed [sbag_pkg::COORD_W-1:0]   dst_origin_x,
  input  logic signed [sbag_pkg::COORD_W-1:0]   dst_origin_y,
  input  logic signed [sbag_pkg::COORD_W-1:0]   dst_extent_w,
  input  logic signed [sbag_pkg::COORD_W-1:0]   dst_extent_h,
  input  logic signed [sbag_pkg::COORD_W-1:0]   src_origin_x,
  input  logic signed [sbag_pkg::COORD_W-1:0]   src_origin_y,
  input  logic signed [sbag_pkg::COORD_W-1:0]   src_extent_w,
  input  logic signed [sbag_pkg::COORD_W-1:0]   src_extent_h,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  pixel_write,
  output logic signed [sbag_pkg::OUT_W-1:0]     dst_col,
  output logic signed [sbag_pkg::OUT_W-1:0]     dst_row,
  output logic signed [sbag_pkg::OUT_W-1:0]     src_col,
  output logic signed [sbag_pkg::OUT_W-1:0]     src_row,
  output logic [sbag_pkg::OFF_W-1:0]            dst_byte_offset,
  output logic [sbag_pkg::OFF_W-1:0]            src_byte_offset,
  output logic [sbag_pkg::BYTES_W-1:0]          pixel_bytes
);

  logic [sbag_pkg::SURF_W-1:0]    dst_surface_width;
  logic [sbag_pkg::SURF_W-1:0]    dst_surface_height;
  logic [sbag_pkg::PIXBITS_W-1:0] dst_pixel_bits;
  logic [sbag_pkg::SURF_W-1:0]    src_surface_width;
  logic [sbag_pkg::SURF_W-1:0]    src_surface_height;
  logic [sbag_pkg::PIXBITS_W-1:0] src_pixel_bits;
  logic [sbag_pkg::STRIDE_W-1:0]  dst_pitch;
  logic [sbag_pkg::STRIDE_W-1:0]  src_pitch;

  logic                           adv;
  logic                           s1_valid;
  sbag_pkg::req_t                 s1;
  logic [sbag_pkg::DIV_STAGES:0]  d_valid;
  sbag_pkg::side_t                d_side [sbag_pkg::DIV_STAGES+1];
  sbag_pkg::div_t                 d_x    [sbag_pkg::DIV_STAGES+1];
  sbag_pkg::div_t                 d_y    [sbag_pkg::DIV_STAGES+1];
  logic                           s3_valid;
  sbag_pkg::coord_t               s3;
  logic                           s4_valid;
  sbag_pkg::coord_t               s4;
  sbag_pkg::ofs_t                 s4_ofs;

  sbag_pkg::side_t                front_side;
  sbag_pkg::div_t                 front_x;
  sbag_pkg::div_t                 front_y;
  logic [sbag_pkg::MAG_W-1:0]     dabs_w;
  logic [sbag_pkg::MAG_W-1:0]     dabs_h;
  logic [sbag_pkg::BYTES_W-1:0]   src_bytes;
  logic [sbag_pkg::BYTES_W-1:0]   dst_bytes;
  logic                           zero_extent;
  logic                           step_out;
  logic                           bytes_bad;

  sbag_pkg::side_t                tail_side;
  sbag_pkg::div_t                 tail_x;
  sbag_pkg::div_t                 tail_y;
  logic [sbag_pkg::OUT_W-1:0]     q_x;
  logic [sbag_pkg::OUT_W-1:0]     q_y;
  sbag_pkg::coord_t               clip;

  logic [sbag_pkg::ROWMUL_W-1:0]  drow_mul;
  logic [sbag_pkg::ROWMUL_W-1:0]  srow_mul;
  logic [sbag_pkg::COLMUL_W-1:0]  dcol_mul;
  logic [sbag_pkg::COLMUL_W-1:0]  scol_mul;

  assign in_stall = out_valid && out_stall;
  assign adv      = !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_surface_width  <= '0;
      dst_surface_height <= '0;
      dst_pixel_bits     <= sbag_pkg::PIXBITS_RESET;
      src_surface_width  <= '0;
      src_surface_height <= '0;
      src_pixel_bits     <= sbag_pkg::PIXBITS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbag_pkg::REG_DST_WIDTH:  dst_surface_width  <= cfg_data[sbag_pkg::SURF_W-1:0];
        sbag_pkg::REG_DST_HEIGHT: dst_surface_height <= cfg_data[sbag_pkg::SURF_W-1:0];
        sbag_pkg::REG_DST_BITS:   dst_pixel_bits     <= cfg_data[sbag_pkg::PIXBITS_W-1:0];
        sbag_pkg::REG_SRC_WIDTH:  src_surface_width  <= cfg_data[sbag_pkg::SURF_W-1:0];
        sbag_pkg::REG_SRC_HEIGHT: src_surface_height <= cfg_data[sbag_pkg::SURF_W-1:0];
        sbag_pkg::REG_SRC_BITS:   src_pixel_bits     <= cfg_data[sbag_pkg::PIXBITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    dst_pitch <= sbag_pkg::row_stride(dst_surface_width, dst_pixel_bits);
    src_pitch <= sbag_pkg::row_stride(src_surface_width, src_pixel_bits);
  end

  assign src_bytes = sbag_pkg::byte_count(src_pixel_bits);
  assign dst_bytes = sbag_pkg::byte_count(dst_pixel_bits);

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1.step_col <= step_col;
      s1.step_row <= step_row;
      s1.dox      <= dst_origin_x;
      s1.doy      <= dst_origin_y;
      s1.dw       <= dst_extent_w;
      s1.dh       <= dst_extent_h;
      s1.sox      <= src_origin_x;
      s1.soy      <= src_origin_y;
      s1.sw       <= src_extent_w;
      s1.sh       <= src_extent_h;
    end
  end

  // front: destination coordinates, checks, step times source extent
  always_comb begin
    dabs_w      = sbag_pkg::magnitude(s1.dw);
    dabs_h      = sbag_pkg::magnitude(s1.dh);
    zero_extent = (s1.dw == '0) || (s1.dh == '0) || (s1.sw == '0) || (s1.sh == '0);
    step_out    = (sbag_pkg::MAG_W'(s1.step_col) >= dabs_w) ||
                  (sbag_pkg::MAG_W'(s1.step_row) >= dabs_h);
    bytes_bad   = (src_bytes == '0) || (src_bytes != dst_bytes);

    front_side.dcol   = sbag_pkg::dest_coord(s1.dox, s1.dw, s1.step_col);
    front_side.drow   = sbag_pkg::dest_coord(s1.doy, s1.dh, s1.step_row);
    front_side.sox    = s1.sox;
    front_side.soy    = s1.soy;
    front_side.sabs_w = sbag_pkg::magnitude(s1.sw);
    front_side.sabs_h = sbag_pkg::magnitude(s1.sh);
    front_side.mir_x  = s1.sw[sbag_pkg::COORD_W-1];
    front_side.mir_y  = s1.sh[sbag_pkg::COORD_W-1];
    front_side.ok     = !zero_extent && !step_out && !bytes_bad &&
                        sbag_pkg::in_surface(front_side.dcol, dst_surface_width) &&
                        sbag_pkg::in_surface(front_side.drow, dst_surface_height);

    front_x.rem     = '0;
    front_x.divisor = dabs_w;
    front_x.word    = sbag_pkg::DIV_W'(sbag_pkg::PROD_W'(s1.step_col) *
                                       sbag_pkg::PROD_W'(front_side.sabs_w));
    front_y.rem     = '0;
    front_y.divisor = dabs_h;
    front_y.word    = sbag_pkg::DIV_W'(sbag_pkg::PROD_W'(s1.step_row) *
                                       sbag_pkg::PROD_W'(front_side.sabs_h));
  end

  // divider pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= '0;
    end else if (adv) begin
      d_valid <= {d_valid[sbag_pkg::DIV_STAGES-1:0], s1_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_side[0] <= front_side;
      d_x[0]    <= front_x;
      d_y[0]    <= front_y;
      for (int k = 0; k < sbag_pkg::DIV_STAGES; k++) begin
        d_side[k+1] <= d_side[k];
        d_x[k+1]    <= sbag_pkg::div_stage(d_x[k]);
        d_y[k+1]    <= sbag_pkg::div_stage(d_y[k]);
      end
    end
  end

  // source coordinates and clip
  always_comb begin
    tail_side = d_side[sbag_pkg::DIV_STAGES];
    tail_x    = d_x[sbag_pkg::DIV_STAGES];
    tail_y    = d_y[sbag_pkg::DIV_STAGES];
    q_x = (tail_x.divisor == '0) ? '0 : tail_x.word[sbag_pkg::OUT_W-1:0];
    q_y = (tail_y.divisor == '0) ? '0 : tail_y.word[sbag_pkg::OUT_W-1:0];
    clip.dcol = tail_side.dcol;
    clip.drow = tail_side.drow;
    clip.scol = sbag_pkg::src_coord(tail_side.sox, tail_side.sabs_w, tail_side.mir_x, q_x);
    clip.srow = sbag_pkg::src_coord(tail_side.soy, tail_side.sabs_h, tail_side.mir_y, q_y);
    clip.ok   = tail_side.ok &&
                sbag_pkg::in_surface(clip.scol, src_surface_width) &&
                sbag_pkg::in_surface(clip.srow, src_surface_height);
  end

  always_comb begin
    drow_mul = sbag_pkg::ROWMUL_W'(s3.drow[sbag_pkg::IDX_W-1:0]) *
               sbag_pkg::ROWMUL_W'(dst_pitch);
    srow_mul = sbag_pkg::ROWMUL_W'(s3.srow[sbag_pkg::IDX_W-1:0]) *
               sbag_pkg::ROWMUL_W'(src_pitch);
    dcol_mul = sbag_pkg::COLMUL_W'(s3.dcol[sbag_pkg::IDX_W-1:0]) *
               sbag_pkg::COLMUL_W'(dst_bytes);
    scol_mul = sbag_pkg::COLMUL_W'(s3.scol[sbag_pkg::IDX_W-1:0]) *
               sbag_pkg::COLMUL_W'(src_bytes);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s3_valid  <= d_valid[sbag_pkg::DIV_STAGES];
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3              <= clip;
      s4              <= s3;
      s4_ofs.drow_ofs <= drow_mul[sbag_pkg::OFF_W-1:0];
      s4_ofs.srow_ofs <= srow_mul[sbag_pkg::OFF_W-1:0];
      s4_ofs.dcol_ofs <= sbag_pkg::OFF_W'(dcol_mul);
      s4_ofs.scol_ofs <= sbag_pkg::OFF_W'(scol_mul);
      pixel_write     <= s4.ok;
      dst_col         <= s4.dcol;
      dst_row         <= s4.drow;
      src_col         <= s4.scol;
      src_row         <= s4.srow;
      dst_byte_offset <= s4.ok ? s4_ofs.drow_ofs + s4_ofs.dcol_ofs : '0;
      src_byte_offset <= s4.ok ? s4_ofs.srow_ofs + s4_ofs.scol_ofs : '0;
      pixel_bytes     <= s4.ok ? src_bytes : '0;
    end
  end

  `SBAG_ASSERT_NOW(a_skip_zero, out_valid && !pixel_write, dst_byte_offset == '0 && src_byte_offset == '0 && pixel_bytes == '0)
  `SBAG_ASSERT_NOW(a_write_inside, out_valid && pixel_write, !dst_col[sbag_pkg::OUT_W-1] && !dst_row[sbag_pkg::OUT_W-1] && !src_col[sbag_pkg::OUT_W-1] && !src_row[sbag_pkg::OUT_W-1] && pixel_bytes != '0)
  `SBAG_ASSERT_NEXT(a_div_entry, d_valid[0] && adv, d_valid[1])
  `SBAG_ASSERT_NEXT(a_final_load, s4_valid && adv, out_valid)

endmodule

`default_nettype wire

/* verif/stretch_blit_address_generator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stretch_blit_address_generator_test
// Self-checking bench for the stretch blit address generator. A table of
// directed requests and surface setups runs first, then random raster walks
// over random geometries mixed with random noise requests. Each accepted
// request is predicted or taken from the table and compared field by field
// with the results in order. Input idles and output stalls at random.
// ----------------------------------------------------------------------------

module stretch_blit_address_generator_test;
  import sbag_pkg::*;

  localparam int REG_COUNT    = 6;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_LIMIT = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);

  typedef logic [REG_COUNT-1:0][CFG_W-1:0] surface_regs_t;

  typedef struct packed {
    logic                    pixel_write;
    logic signed [OUT_W-1:0] dst_col;
    logic signed [OUT_W-1:0] dst_row;
    logic signed [OUT_W-1:0] src_col;
    logic signed [OUT_W-1:0] src_row;
    logic [OFF_W-1:0]        dst_byte_offset;
    logic [OFF_W-1:0]        src_byte_offset;
    logic [BYTES_W-1:0]      pixel_bytes;
  } blit_res_t;

  typedef enum logic [1:0] {ROW_SURFACES, ROW_PIXEL, ROW_CHECKED} row_kind_e;

  typedef struct packed {
    row_kind_e     kind;
    surface_regs_t regs;
    req_t          req;
    blit_res_t     want;
  } plan_row_t;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]            cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [STEP_W-1:0]           step_col = '0;
  logic [STEP_W-1:0]           step_row = '0;
  logic signed [COORD_W-1:0]   dst_origin_x = '0;
  logic signed [COORD_W-1:0]   dst_origin_y = '0;
  logic signed [COORD_W-1:0]   dst_extent_w = '0;
  logic signed [COORD_W-1:0]   dst_extent_h = '0;
  logic signed [COORD_W-1:0]   src_origin_x = '0;
  logic signed [COORD_W-1:0]   src_origin_y = '0;
  logic signed [COORD_W-1:0]   src_extent_w = '0;
  logic signed [COORD_W-1:0]   src_extent_h = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        pixel_write;
  logic signed [OUT_W-1:0]     dst_col;
  logic signed [OUT_W-1:0]     dst_row;
  logic signed [OUT_W-1:0]     src_col;
  logic signed [OUT_W-1:0]     src_row;
  logic [OFF_W-1:0]            dst_byte_offset;
  logic [OFF_W-1:0]            src_byte_offset;
  logic [BYTES_W-1:0]          pixel_bytes;

  logic                        req_typed = 1'b0;
  blit_res_t                   req_typed_want = '0;

  logic [SURF_W-1:0]           dst_width_reg;
  logic [SURF_W-1:0]           dst_height_reg;
  logic [PIXBITS_W-1:0]        dst_bits_reg;
  logic [SURF_W-1:0]           src_width_reg;
  logic [SURF_W-1:0]           src_height_reg;
  logic [PIXBITS_W-1:0]        src_bits_reg;

  blit_res_t                   pending_pixels[$];
  int                          mismatch_count = 0;
  int                          cycle_count = 0;
  int                          random_sent = 0;
  int                          gap_pct = 0;
  int                          stall_pct = 0;
  int                          stall_left = 0;

  stretch_blit_address_generator uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .step_col(step_col), .step_row(step_row),
    .dst_origin_x(dst_origin_x), .dst_origin_y(dst_origin_y),
    .dst_extent_w(dst_extent_w), .dst_extent_h(dst_extent_h),
    .src_origin_x(src_origin_x), .src_origin_y(src_origin_y),
    .src_extent_w(src_extent_w), .src_extent_h(src_extent_h),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel_write(pixel_write),
    .dst_col(dst_col), .dst_row(dst_row), .src_col(src_col), .src_row(src_row),
    .dst_byte_offset(dst_byte_offset), .src_byte_offset(src_byte_offset),
    .pixel_bytes(pixel_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint abs_len(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint stride_bytes(input longint width, input longint bits);
    return ((width * bits + ROW_ALIGN_BITS - 1) / ROW_ALIGN_BITS) * ROW_ALIGN_BYTES;
  endfunction

  function automatic blit_res_t predict_pixel(input req_t r);
    blit_res_t res;
    longint    sc, sr, dox, doy, dw, dh, sox, soy, sw, sh;
    longint    dw_abs, dh_abs, sw_abs, sh_abs, qx, qy;
    longint    dcol, drow, scol, srow, sbytes, dbytes;
    longint    dsw, dsh, ssw, ssh;
    logic      ok;
    res = '0;
    sc = r.step_col;
    sr = r.step_row;
    dox = $signed(r.dox);
    doy = $signed(r.doy);
    dw = $signed(r.dw);
    dh = $signed(r.dh);
    sox = $signed(r.sox);
    soy = $signed(r.soy);
    sw = $signed(r.sw);
    sh = $signed(r.sh);
    dsw = dst_width_reg;
    dsh = dst_height_reg;
    ssw = src_width_reg;
    ssh = src_height_reg;
    dw_abs = abs_len(dw);
    dh_abs = abs_len(dh);
    sw_abs = abs_len(sw);
    sh_abs = abs_len(sh);
    dcol = dox + ((dw < 0) ? dw_abs - 1 - sc : sc);
    drow = doy + ((dh < 0) ? dh_abs - 1 - sr : sr);
    qx = (dw_abs == 0) ? 0 : sc * sw_abs / dw_abs;
    qy = (dh_abs == 0) ? 0 : sr * sh_abs / dh_abs;
    scol = (sw < 0) ? sox + sw_abs - 1 - qx : sox + qx;
    srow = (sh < 0) ? soy + sh_abs - 1 - qy : soy + qy;
    sbytes = src_bits_reg / BITS_PER_BYTE;
    dbytes = dst_bits_reg / BITS_PER_BYTE;
    ok = dw != 0 && dh != 0 && sw != 0 && sh != 0
      && sc < dw_abs && sr < dh_abs
      && sbytes != 0 && sbytes == dbytes
      && drow >= 0 && drow < dsh && srow >= 0 && srow < ssh
      && dcol >= 0 && dcol < dsw && scol >= 0 && scol < ssw;
    res.pixel_write = ok;
    res.dst_col = OUT_W'(dcol);
    res.dst_row = OUT_W'(drow);
    res.src_col = OUT_W'(scol);
    res.src_row = OUT_W'(srow);
    if (ok) begin
      res.dst_byte_offset = OFF_W'(drow * stride_bytes(dsw, dst_bits_reg) + dcol * dbytes);
      res.src_byte_offset = OFF_W'(srow * stride_bytes(ssw, src_bits_reg) + scol * sbytes);
      res.pixel_bytes = BYTES_W'(sbytes);
    end
    return res;
  endfunction

  function automatic string show(input blit_res_t r);
    return $sformatf("write=%0d dst=(%0d,%0d) src=(%0d,%0d) offs=%0h/%0h bytes=%0d",
                     r.pixel_write, r.dst_col, r.dst_row, r.src_col, r.src_row,
                     r.dst_byte_offset, r.src_byte_offset, r.pixel_bytes);
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  task automatic check_pixel(input blit_res_t got, input blit_res_t want);
    string bad;
    bad = "";
    if (got.pixel_write !== want.pixel_write) bad = {bad, " pixel_write"};
    if (got.dst_col !== want.dst_col) bad = {bad, " dst_col"};
    if (got.dst_row !== want.dst_row) bad = {bad, " dst_row"};
    if (got.src_col !== want.src_col) bad = {bad, " src_col"};
    if (got.src_row !== want.src_row) bad = {bad, " src_row"};
    if (got.dst_byte_offset !== want.dst_byte_offset) bad = {bad, " dst_byte_offset"};
    if (got.src_byte_offset !== want.src_byte_offset) bad = {bad, " src_byte_offset"};
    if (got.pixel_bytes !== want.pixel_bytes) bad = {bad, " pixel_bytes"};
    if (bad != "")
      note_failure($sformatf("mismatch in%s: expected %s, got %s", bad, show(want), show(got)));
  endtask

  always @(posedge clk) begin : track
    blit_res_t got;
    req_t      taken;
    if (rst) begin
      dst_width_reg = '0;
      dst_height_reg = '0;
      dst_bits_reg = PIXBITS_RESET;
      src_width_reg = '0;
      src_height_reg = '0;
      src_bits_reg = PIXBITS_RESET;
      pending_pixels.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {pixel_write, dst_col, dst_row, src_col, src_row,
               dst_byte_offset, src_byte_offset, pixel_bytes};
        if (pending_pixels.size() == 0) note_failure($sformatf("unexpected result %s", show(got)));
        else check_pixel(got, pending_pixels.pop_front());
      end
      if (in_valid && !in_stall) begin
        taken = {step_col, step_row, dst_origin_x, dst_origin_y, dst_extent_w, dst_extent_h,
                 src_origin_x, src_origin_y, src_extent_w, src_extent_h};
        pending_pixels.push_back(req_typed ? req_typed_want : predict_pixel(taken));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DST_WIDTH:  dst_width_reg = SURF_W'(cfg_data);
          REG_DST_HEIGHT: dst_height_reg = SURF_W'(cfg_data);
          REG_DST_BITS:   dst_bits_reg = PIXBITS_W'(cfg_data);
          REG_SRC_WIDTH:  src_width_reg = SURF_W'(cfg_data);
          REG_SRC_HEIGHT: src_height_reg = SURF_W'(cfg_data);
          REG_SRC_BITS:   src_bits_reg = PIXBITS_W'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("stretch_blit_address_generator_test: FAIL");
      $finish;
    end
  end

  function automatic req_t make_req(input int sc, sr, dox, doy, dw, dh, sox, soy, sw, sh);
    req_t r;
    r.step_col = STEP_W'(sc);
    r.step_row = STEP_W'(sr);
    r.dox = COORD_W'(dox);
    r.doy = COORD_W'(doy);
    r.dw = COORD_W'(dw);
    r.dh = COORD_W'(dh);
    r.sox = COORD_W'(sox);
    r.soy = COORD_W'(soy);
    r.sw = COORD_W'(sw);
    r.sh = COORD_W'(sh);
    return r;
  endfunction

  function automatic plan_row_t surfaces_row(input int dw, dh, db, sw, sh, sb);
    plan_row_t row;
    row = '0;
    row.kind = ROW_SURFACES;
    row.regs[REG_DST_WIDTH] = CFG_W'(dw);
    row.regs[REG_DST_HEIGHT] = CFG_W'(dh);
    row.regs[REG_DST_BITS] = CFG_W'(db);
    row.regs[REG_SRC_WIDTH] = CFG_W'(sw);
    row.regs[REG_SRC_HEIGHT] = CFG_W'(sh);
    row.regs[REG_SRC_BITS] = CFG_W'(sb);
    return row;
  endfunction

  function automatic plan_row_t pixel_row(input int sc, sr, dox, doy, dw, dh,
                                          input int sox, soy, sw, sh);
    plan_row_t row;
    row = '0;
    row.kind = ROW_PIXEL;
    row.req = make_req(sc, sr, dox, doy, dw, dh, sox, soy, sw, sh);
    return row;
  endfunction

  function automatic plan_row_t checked_row(input plan_row_t row, input int pw,
                                            input int dcol, drow, scol, srow,
                                            input int doff, soff, nb);
    row.kind = ROW_CHECKED;
    row.want = {1'(pw), OUT_W'(dcol), OUT_W'(drow), OUT_W'(scol), OUT_W'(srow),
                OFF_W'(doff), OFF_W'(soff), BYTES_W'(nb)};
    return row;
  endfunction

  task automatic send_request(input req_t r, input logic typed, input blit_res_t want);
    {step_col, step_row, dst_origin_x, dst_origin_y, dst_extent_w, dst_extent_h,
     src_origin_x, src_origin_y, src_extent_w, src_extent_h} <= r;
    req_typed <= typed;
    req_typed_want <= want;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_requests();
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic load_config(input surface_regs_t regs);
    wait_idle();
    for (int i = 0; i < REG_COUNT; i++) write_register(CFG_IDX_W'(i), regs[i]);
    write_register(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO, CFG_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic send_random(input req_t r);
    send_request(r, 1'b0, '0);
    random_sent++;
    idle_requests();
  endtask

  function automatic int place(input int size, input int ext);
    int span, base;
    span = size - int'(abs_len(ext));
    base = (span > 0) ? $urandom_range(0, span) : 0;
    if ($urandom_range(0, 4) == 0) base = base + $urandom_range(0, 6) - 3;
    return base;
  endfunction

  function automatic int flip(input int v);
    return ($urandom_range(0, 9) < 3) ? -v : v;
  endfunction

  function automatic int surface_extent(input int style);
    case (style)
      0: return $urandom_range(1, 64);
      1: return $urandom_range(64, 2048);
      2: return ($urandom_range(0, 1) != 0) ? 16384 : 32767;
      3: return $urandom_range(0, 32767);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  // walk a raster over one random geometry, or a few steps of a wide one
  task automatic send_sequence(input int dsw, dsh, ssw, ssh);
    int  dw, dh, sw, sh, dox, doy, sox, soy, extra;
    bit  wide;
    wide = ($urandom_range(0, 9) == 0);
    if (wide) begin
      dw = flip($urandom_range(1, 32768));
      dh = flip($urandom_range(1, 32768));
      sw = flip($urandom_range(1, 32768));
      sh = flip($urandom_range(1, 32768));
    end else begin
      dw = flip($urandom_range(1, 12));
      dh = flip($urandom_range(1, 12));
      sw = flip($urandom_range(1, 40));
      sh = flip($urandom_range(1, 40));
    end
    dox = place(dsw, dw);
    doy = place(dsh, dh);
    sox = place(ssw, sw);
    soy = place(ssh, sh);
    if (wide) begin
      repeat (8)
        send_random(make_req($urandom_range(0, abs_len(dw) - 1), $urandom_range(0, abs_len(dh) - 1),
                             dox, doy, dw, dh, sox, soy, sw, sh));
    end else begin
      extra = ($urandom_range(0, 9) == 0) ? 1 : 0;
      for (int r = 0; r < abs_len(dh) + extra; r++)
        for (int c = 0; c < abs_len(dw) + extra; c++)
          send_random(make_req(c, r, dox, doy, dw, dh, sox, soy, sw, sh));
    end
  endtask

  initial begin : stimulus
    plan_row_t     plan[$];
    plan_row_t     row;
    int            style, db, sb, phase, target;
    int            paces[4];
    plan.push_back(checked_row(pixel_row(0, 0, 0, 0, 1, 1, 0, 0, 1, 1), 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(pixel_row(32767, 32767, -32768, -32768, -32768, -32768,
                             -32768, -32768, -32768, -32768));
    plan.push_back(surfaces_row(64, 48, 32, 40, 30, 32));
    plan.push_back(pixel_row(3, 5, 10, 20, 8, 8, 0, 0, 8, 8));
    plan.push_back(pixel_row(7, 5, 0, 0, 16, 12, 0, 0, 8, 6));
    plan.push_back(pixel_row(3, 3, 0, 0, 4, 4, 0, 0, 32, 24));
    plan.push_back(pixel_row(0, 0, 4, 4, -16, 8, 0, 0, 16, 8));
    plan.push_back(pixel_row(2, 6, 4, 4, 16, 8, 0, 0, 16, -8));
    plan.push_back(pixel_row(5, 1, 10, 10, -6, -3, 1, 2, -12, -9));
    plan.push_back(checked_row(pixel_row(2, 3, 5, 6, 0, 4, 1, 1, 8, 8), 0, 7, 9, 1, 7, 0, 0, 0));
    plan.push_back(checked_row(pixel_row(1, 1, 0, 0, 4, 4, 0, 0, 4, 0), 0, 1, 1, 1, 0, 0, 0, 0));
    plan.push_back(pixel_row(4, 0, 0, 0, 4, 4, 0, 0, 4, 4));
    plan.push_back(pixel_row(0, 0, -1, 0, 4, 4, 0, 0, 4, 4));
    plan.push_back(pixel_row(1, 0, 63, 0, 4, 4, 0, 0, 4, 4));
    plan.push_back(pixel_row(0, 3, 0, 0, 4, 4, 0, 28, 4, 4));
    plan.push_back(pixel_row(32766, 32766, 32767, 32767, 32767, 32767, 0, 0, 1, 1));
    plan.push_back(pixel_row(0, 0, 0, 0, 1, 1, 0, 0, -32768, -32768));
    plan.push_back(surfaces_row(64, 48, 16, 40, 30, 24));
    plan.push_back(checked_row(pixel_row(0, 0, 0, 0, 1, 1, 0, 0, 1, 1), 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(surfaces_row(64, 48, 7, 40, 30, 7));
    plan.push_back(checked_row(pixel_row(0, 0, 0, 0, 1, 1, 0, 0, 1, 1), 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(surfaces_row(32767, 32767, 32767, 16384, 16384, 32767));
    plan.push_back(pixel_row(766, 766, 32000, 32000, 767, 767, 16000, 16000, 384, 384));
    plan.push_back(pixel_row(0, 0, 0, 0, 1, 1, 0, 0, 1, 1));
    plan.push_back(surfaces_row(0, 0, 0, 0, 0, 0));
    plan.push_back(checked_row(pixel_row(0, 0, 0, 0, 1, 1, 0, 0, 1, 1), 0, 0, 0, 0, 0, 0, 0, 0));
    paces = '{0, 5, 20, 50};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    gap_pct = 20;
    stall_pct = 20;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SURFACES) begin
        load_config(plan[i].regs);
      end else begin
        send_request(plan[i].req, plan[i].kind == ROW_CHECKED, plan[i].want);
        idle_requests();
      end
    end

    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      style = $urandom_range(0, 4);
      if ($urandom_range(0, 5) == 0) begin
        db = $urandom_range(0, 63);
        sb = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 63) : ((db & ~7) | $urandom_range(0, 7));
      end else begin
        db = BITS_PER_BYTE * $urandom_range(1, 4);
        sb = db;
      end
      row = surfaces_row(surface_extent(style), surface_extent(style), db,
                         surface_extent(style), surface_extent(style), sb);
      if ($urandom_range(0, 1) != 0) begin
        row.regs[REG_DST_BITS] = row.regs[REG_DST_BITS] | (CFG_W'($urandom) << PIXBITS_W);
        row.regs[REG_SRC_BITS] = row.regs[REG_SRC_BITS] | (CFG_W'($urandom) << PIXBITS_W);
      end
      load_config(row.regs);
      gap_pct = (phase == 0) ? 0 : paces[$urandom_range(0, 3)];
      stall_pct = (phase == 0) ? 0 : paces[$urandom_range(0, 3)];
      target = random_sent + $urandom_range(100, 160);
      while (random_sent < target) begin
        if ($urandom_range(0, 4) == 0)
          send_random(make_req($urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom, $urandom));
        else
          send_sequence(row.regs[REG_DST_WIDTH], row.regs[REG_DST_HEIGHT],
                        row.regs[REG_SRC_WIDTH], row.regs[REG_SRC_HEIGHT]);
      end
      phase++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_pixels.size() == 0)
      $display("stretch_blit_address_generator_test: PASS");
    else
      $display("stretch_blit_address_generator_test: FAIL");
    $finish;
  end

endmodule
